// ===== rtl/core/dds_header_validator_top_assert.svh =====
// Assertion macros shared by the validator modules.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef DDS_HEADER_VALIDATOR_TOP_ASSERT_SVH
`define DDS_HEADER_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define DHV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define DHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DHV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define DHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dhv_pkg.sv =====
package dhv_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned OUT_TDATA_W    = 136;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h2053_4444;

    typedef enum logic [2:0] {
        FMT_BGR24       = 3'd0,
        FMT_RGB24       = 3'd1,
        FMT_BGRA32      = 3'd2,
        FMT_RGBA32      = 3'd3,
        FMT_GRAY8       = 3'd4,
        FMT_GRAYALPHA16 = 3'd5
    } fmt_t;

    // One finished header, handed from the word checker to the verdict unit.
    typedef struct packed {
        logic              rejected;
        logic              fmt_ok;
        fmt_t              fmt;
        logic              pitch_en;
        logic [WORD_W-1:0] height;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] pitch;
    } hdr_job_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_STRIDE = 2'd1,
        BK_MUL    = 2'd2,
        BK_OUT    = 2'd3
    } back_state_t;

    function automatic logic [2:0] pixel_bytes(input fmt_t f);
        logic [2:0] pb;
        unique case (f)
            FMT_BGR24, FMT_RGB24:   pb = 3'd3;
            FMT_BGRA32, FMT_RGBA32: pb = 3'd4;
            FMT_GRAY8:              pb = 3'd1;
            FMT_GRAYALPHA16:        pb = 3'd2;
            default:                pb = 3'd1;
        endcase
        return pb;
    endfunction

endpackage

// ===== rtl/core/dds_header_validator_top.sv =====
// DDS header validator for uncompressed textures.
// Input channel (s_*): one beat per 32-bit little-endian header word; s_tuser set
// marks word zero, the magic, and restarts the word count. Beats without a start
// mark while no header is open are taken and dropped.
// Output channel (m_*): one beat per complete 32-word header. m_tuser is the
// accepted bit; m_tdata carries format, width, height, row stride and byte count,
// all zero when the header is rejected.
// Configuration channel (cfg_*): writes the expected magic word; always ready.
// Throughput: one header word per cycle. The verdict unit takes each header through
// queue pop, stride check, 32x32 multiply and output load quicker than the 32
// beats a header takes on the input, so the input only stalls while the
// two-entry job queue is full.
// After the edge that takes the last header word, the job passes through the queue
// and the BK_IDLE, BK_STRIDE, BK_MUL and BK_OUT states before m_tvalid rises.
// Reset (aresetn low, synchronous) empties the queue and output register, closes
// any open header and restores the magic to "DDS ". When the receiver holds
// m_tready low, the verdict waits in the output register, the verdict unit waits
// behind it, and the queue fills before s_tready drops.
module dds_header_validator_top
    import dhv_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_W-1:0]      s_tdata,    // [31:0] header_word
    input  logic                   s_tuser,    // [0] start_of_header
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] pixel_format, [34:3] image_width, [66:35] image_height,
    // [98:67] row_stride, [130:99] image_bytes, [135:131] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser     // [0] accepted
);

    hdr_job_t push_job;
    hdr_job_t pop_job;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;

    // Front: per-word checks and field capture, one job per finished header.
    dhv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Job queue decoupling word intake from verdict computation.
    dhv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    // Back: stride and size overflow checks, then the registered verdict beat.
    dhv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== rtl/core/dhv_front.sv =====
module dhv_front
    import dhv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              q_full,
    output logic              q_push,
    output hdr_job_t          q_job
);

    localparam logic [4:0] IDX_MAGIC  = 5'd0;
    localparam logic [4:0] IDX_SIZE   = 5'd1;
    localparam logic [4:0] IDX_FLAGS  = 5'd2;
    localparam logic [4:0] IDX_HEIGHT = 5'd3;
    localparam logic [4:0] IDX_WIDTH  = 5'd4;
    localparam logic [4:0] IDX_PITCH  = 5'd5;
    localparam logic [4:0] IDX_PFSIZE = 5'd19;
    localparam logic [4:0] IDX_PFFLAG = 5'd20;
    localparam logic [4:0] IDX_BITCNT = 5'd22;
    localparam logic [4:0] IDX_RMASK  = 5'd23;
    localparam logic [4:0] IDX_GMASK  = 5'd24;
    localparam logic [4:0] IDX_BMASK  = 5'd25;
    localparam logic [4:0] IDX_AMASK  = 5'd26;
    localparam logic [4:0] IDX_CAPS   = 5'd27;
    localparam logic [4:0] IDX_LAST   = 5'd31;

    localparam logic [WORD_W-1:0] HEADER_SIZE  = 32'd124;
    localparam logic [WORD_W-1:0] PIXFMT_SIZE  = 32'd32;
    localparam logic [WORD_W-1:0] FLAG_CAPS    = 32'h1;
    localparam logic [WORD_W-1:0] FLAG_HEIGHT  = 32'h2;
    localparam logic [WORD_W-1:0] FLAG_WIDTH   = 32'h4;
    localparam logic [WORD_W-1:0] FLAG_PITCH   = 32'h8;
    localparam logic [WORD_W-1:0] FLAG_PIXFMT  = 32'h1000;
    localparam logic [WORD_W-1:0] CAPS_TEXTURE = 32'h1000;
    localparam logic [WORD_W-1:0] PF_ALPHA     = 32'h1;
    localparam logic [WORD_W-1:0] PF_RGB       = 32'h40;
    localparam logic [WORD_W-1:0] PF_LUM       = 32'h20000;
    localparam logic [WORD_W-1:0] MASK_B0      = 32'h0000_00ff;
    localparam logic [WORD_W-1:0] MASK_B1      = 32'h0000_ff00;
    localparam logic [WORD_W-1:0] MASK_B2      = 32'h00ff_0000;
    localparam logic [WORD_W-1:0] MASK_B3      = 32'hff00_0000;
    localparam logic [WORD_W-1:0] FLAGS_REQ    = FLAG_HEIGHT | FLAG_WIDTH;
    localparam logic [WORD_W-1:0] FLAGS_OK     = FLAGS_REQ | FLAG_CAPS | FLAG_PITCH | FLAG_PIXFMT;

    logic [WORD_W-1:0] magic_reg;
    logic [4:0]        word_idx_reg,  word_idx_next;
    logic              active_reg,    active_next;
    logic              reject_reg,    reject_next;
    logic              pitch_en_reg,  pitch_en_next;
    logic [WORD_W-1:0] height_reg,    height_next;
    logic [WORD_W-1:0] width_reg,     width_next;
    logic [WORD_W-1:0] pitch_reg,     pitch_next;
    logic [WORD_W-1:0] pf_flags_reg,  pf_flags_next;
    logic [WORD_W-1:0] bit_cnt_reg,   bit_cnt_next;
    logic [WORD_W-1:0] rmask_reg,     rmask_next;
    logic [WORD_W-1:0] gmask_reg,     gmask_next;
    logic [WORD_W-1:0] bmask_reg,     bmask_next;
    logic [WORD_W-1:0] amask_reg,     amask_next;

    logic       take;
    logic       in_hdr;
    logic       last_word;
    logic       bad;
    logic [4:0] eff_idx;
    logic       fmt_ok;
    fmt_t       fmt;

    assign cfg_ready = 1'b1;
    // The queue holds the verdict jobs; words only stall when it is full.
    assign s_tready  = !q_full;

    assign take      = s_tvalid && s_tready;
    assign eff_idx   = s_tuser ? IDX_MAGIC : word_idx_reg;
    assign in_hdr    = s_tuser || active_reg;
    assign last_word = in_hdr && (eff_idx == IDX_LAST);

    // Per-word field check.
    always_comb begin
        unique case (eff_idx)
            IDX_MAGIC:  bad = (s_tdata != magic_reg);
            IDX_SIZE:   bad = (s_tdata != HEADER_SIZE);
            IDX_FLAGS:  bad = ((s_tdata & FLAGS_REQ) != FLAGS_REQ) ||
                              ((s_tdata & ~FLAGS_OK) != '0);
            IDX_HEIGHT: bad = (s_tdata == '0);
            IDX_WIDTH:  bad = (s_tdata == '0);
            IDX_PITCH:  bad = 1'b0;
            IDX_PFSIZE: bad = (s_tdata != PIXFMT_SIZE);
            IDX_PFFLAG: bad = 1'b0;
            IDX_BITCNT: bad = 1'b0;
            IDX_RMASK:  bad = 1'b0;
            IDX_GMASK:  bad = 1'b0;
            IDX_BMASK:  bad = 1'b0;
            IDX_AMASK:  bad = 1'b0;
            IDX_CAPS:   bad = ((s_tdata & ~CAPS_TEXTURE) != '0);
            default:    bad = (s_tdata != '0);
        endcase
    end

    // Pixel format decode from the stored mask words.
    always_comb begin
        fmt_ok = 1'b0;
        fmt    = FMT_BGR24;
        if (pf_flags_reg == PF_RGB) begin
            if (bit_cnt_reg == 32'd24 && gmask_reg == MASK_B1 && amask_reg == '0) begin
                if (rmask_reg == MASK_B2 && bmask_reg == MASK_B0) begin
                    fmt_ok = 1'b1;
                    fmt    = FMT_BGR24;
                end else if (rmask_reg == MASK_B0 && bmask_reg == MASK_B2) begin
                    fmt_ok = 1'b1;
                    fmt    = FMT_RGB24;
                end
            end
        end else if (pf_flags_reg == (PF_RGB | PF_ALPHA)) begin
            if (bit_cnt_reg == 32'd32 && gmask_reg == MASK_B1 && amask_reg == MASK_B3) begin
                if (rmask_reg == MASK_B2 && bmask_reg == MASK_B0) begin
                    fmt_ok = 1'b1;
                    fmt    = FMT_BGRA32;
                end else if (rmask_reg == MASK_B0 && bmask_reg == MASK_B2) begin
                    fmt_ok = 1'b1;
                    fmt    = FMT_RGBA32;
                end
            end
        end else if (pf_flags_reg == PF_LUM) begin
            if (bit_cnt_reg == 32'd8 && rmask_reg == MASK_B0 && gmask_reg == '0 &&
                bmask_reg == '0 && amask_reg == '0) begin
                fmt_ok = 1'b1;
                fmt    = FMT_GRAY8;
            end
        end else if (pf_flags_reg == (PF_LUM | PF_ALPHA)) begin
            if (bit_cnt_reg == 32'd16 && rmask_reg == MASK_B0 && gmask_reg == '0 &&
                bmask_reg == '0 && amask_reg == MASK_B1) begin
                fmt_ok = 1'b1;
                fmt    = FMT_GRAYALPHA16;
            end
        end
    end

    always_comb begin
        word_idx_next = word_idx_reg;
        active_next   = active_reg;
        reject_next   = reject_reg;
        pitch_en_next = pitch_en_reg;
        height_next   = height_reg;
        width_next    = width_reg;
        pitch_next    = pitch_reg;
        pf_flags_next = pf_flags_reg;
        bit_cnt_next  = bit_cnt_reg;
        rmask_next    = rmask_reg;
        gmask_next    = gmask_reg;
        bmask_next    = bmask_reg;
        amask_next    = amask_reg;
        if (take && in_hdr) begin
            reject_next = (s_tuser ? 1'b0 : reject_reg) | bad;
            if (last_word) begin
                active_next   = 1'b0;
                word_idx_next = IDX_MAGIC;
            end else begin
                active_next   = 1'b1;
                word_idx_next = eff_idx + 5'd1;
            end
            unique case (eff_idx)
                IDX_FLAGS:  pitch_en_next = (s_tdata & FLAG_PITCH) != '0;
                IDX_HEIGHT: height_next   = s_tdata;
                IDX_WIDTH:  width_next    = s_tdata;
                IDX_PITCH:  pitch_next    = s_tdata;
                IDX_PFFLAG: pf_flags_next = s_tdata;
                IDX_BITCNT: bit_cnt_next  = s_tdata;
                IDX_RMASK:  rmask_next    = s_tdata;
                IDX_GMASK:  gmask_next    = s_tdata;
                IDX_BMASK:  bmask_next    = s_tdata;
                IDX_AMASK:  amask_next    = s_tdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        q_push         = take && last_word;
        q_job.rejected = reject_reg | bad;
        q_job.fmt_ok   = fmt_ok;
        q_job.fmt      = fmt;
        q_job.pitch_en = pitch_en_reg;
        q_job.height   = height_reg;
        q_job.width    = width_reg;
        q_job.pitch    = pitch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= MAGIC_RESET;
            word_idx_reg <= '0;
            active_reg   <= 1'b0;
            reject_reg   <= 1'b0;
            pitch_en_reg <= 1'b0;
            height_reg   <= '0;
            width_reg    <= '0;
            pitch_reg    <= '0;
            pf_flags_reg <= '0;
            bit_cnt_reg  <= '0;
            rmask_reg    <= '0;
            gmask_reg    <= '0;
            bmask_reg    <= '0;
            amask_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                magic_reg <= cfg_data;
            end
            word_idx_reg <= word_idx_next;
            active_reg   <= active_next;
            reject_reg   <= reject_next;
            pitch_en_reg <= pitch_en_next;
            height_reg   <= height_next;
            width_reg    <= width_next;
            pitch_reg    <= pitch_next;
            pf_flags_reg <= pf_flags_next;
            bit_cnt_reg  <= bit_cnt_next;
            rmask_reg    <= rmask_next;
            gmask_reg    <= gmask_next;
            bmask_reg    <= bmask_next;
            amask_reg    <= amask_next;
        end
    end

endmodule

// ===== rtl/core/dhv_queue.sv =====
`include "dds_header_validator_top_assert.svh"

module dhv_queue
    import dhv_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  hdr_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output hdr_job_t pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hdr_job_t         slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_job   = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DHV_ASSERT_SAME(a_no_push_when_full, aclk, aresetn, push, !full, "job pushed into a full queue")
    `DHV_ASSERT_NEXT(a_pop_drains, aclk, aresetn, do_pop && !do_push,
        count_reg == $past(count_reg) - CNT_W'(1), "queue count did not drop on pop")

endmodule

// ===== rtl/core/dhv_back.sv =====
`include "dds_header_validator_top_assert.svh"

module dhv_back
    import dhv_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  hdr_job_t               q_job,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    back_state_t state_reg, state_next;

    hdr_job_t               job_reg;
    logic [WORD_W-1:0]      stride_reg;
    logic                   ok_reg;
    logic [2*WORD_W-1:0]    prod_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_user_reg;

    logic                   out_free;
    logic                   load_out;
    logic [WORD_W+1:0]      packed_row;
    logic                   stride_ok;
    logic                   final_ok;

    assign out_free = !m_valid_reg || m_tready;

    // Packed row is at most four bytes per pixel, so two extra bits catch overflow.
    assign packed_row = {2'b00, job_reg.width} * {{(WORD_W-1){1'b0}}, pixel_bytes(job_reg.fmt)};
    assign stride_ok  = !job_reg.rejected && job_reg.fmt_ok && (packed_row[WORD_W+1:WORD_W] == 2'b00) &&
                        (!job_reg.pitch_en || (job_reg.pitch >= packed_row[WORD_W-1:0]));
    assign final_ok   = ok_reg && (prod_reg[2*WORD_W-1:WORD_W] == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (q_not_empty) state_next = BK_STRIDE;
            BK_STRIDE: state_next = BK_MUL;
            BK_MUL:    state_next = BK_OUT;
            BK_OUT:    if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == BK_IDLE) && q_not_empty;
        load_out = (state_reg == BK_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (state_reg == BK_STRIDE) begin
            ok_reg     <= stride_ok;
            stride_reg <= job_reg.pitch_en ? job_reg.pitch : packed_row[WORD_W-1:0];
        end
        if (state_reg == BK_MUL) begin
            prod_reg <= {{WORD_W{1'b0}}, stride_reg} * {{WORD_W{1'b0}}, job_reg.height};
        end
        if (load_out) begin
            m_user_reg <= final_ok;
            if (final_ok) begin
                m_data_reg <= {5'b00000, prod_reg[WORD_W-1:0], stride_reg, job_reg.height,
                               job_reg.width, job_reg.fmt};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `DHV_ASSERT_NEXT(a_reject_zero, aclk, aresetn, load_out && !final_ok,
        m_tvalid && !m_tuser && (m_tdata == '0), "rejected verdict carries nonzero fields")
    `DHV_ASSERT_NEXT(a_mul_follows_stride, aclk, aresetn, state_reg == BK_STRIDE,
        state_reg == BK_MUL, "verdict sequence skipped the multiply step")

endmodule

// ===== dv/dds_header_validator_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the DDS header validator. Header words go in as
// one beat each on the s_ channel; the single verdict beat per complete
// header comes out on the m_ channel. A predictor runs on every accepted
// input beat and queues the verdict it works out. Every verdict beat is
// compared with the oldest queued one, field by field.
module dds_header_validator_top_tb;
    import dhv_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    // Settling time given once every queued verdict has arrived.
    localparam int DRAIN_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int HOLD_CYCLES      = 400;
    localparam int PRESSURE_HEADERS = 5;
    localparam int PHASE_HEADERS    = 2;

    // Word positions inside the 32-word header.
    localparam int HDR_WORDS  = 32;
    localparam int W_MAGIC    = 0;
    localparam int W_SIZE     = 1;
    localparam int W_FLAGS    = 2;
    localparam int W_HEIGHT   = 3;
    localparam int W_WIDTH    = 4;
    localparam int W_PITCH    = 5;
    localparam int W_DEPTH    = 6;
    localparam int W_PF_SIZE  = 19;
    localparam int W_PF_FLAGS = 20;
    localparam int W_FOURCC   = 21;
    localparam int W_BITCOUNT = 22;
    localparam int W_RMASK    = 23;
    localparam int W_GMASK    = 24;
    localparam int W_BMASK    = 25;
    localparam int W_AMASK    = 26;
    localparam int W_CAPS     = 27;
    localparam int W_LAST     = 31;
    localparam int NO_PATCH   = -1;

    localparam logic [31:0] HDR_SIZE     = 32'd124;
    localparam logic [31:0] PF_SIZE      = 32'd32;
    localparam logic [31:0] FL_CAPS      = 32'h0000_0001;
    localparam logic [31:0] FL_HEIGHT    = 32'h0000_0002;
    localparam logic [31:0] FL_WIDTH     = 32'h0000_0004;
    localparam logic [31:0] FL_PITCH     = 32'h0000_0008;
    localparam logic [31:0] FL_PIXFMT    = 32'h0000_1000;
    localparam logic [31:0] FLAGS_BASE   = FL_CAPS | FL_HEIGHT | FL_WIDTH | FL_PIXFMT;
    localparam logic [31:0] FLAGS_ALLOWED = FLAGS_BASE | FL_PITCH;
    localparam logic [31:0] CAPS_TEXTURE = 32'h0000_1000;
    localparam logic [31:0] PF_ALPHA     = 32'h0000_0001;
    localparam logic [31:0] PF_RGB       = 32'h0000_0040;
    localparam logic [31:0] PF_LUM       = 32'h0002_0000;
    localparam logic [31:0] MASK_B0      = 32'h0000_00ff;
    localparam logic [31:0] MASK_B1      = 32'h0000_ff00;
    localparam logic [31:0] MASK_B2      = 32'h00ff_0000;
    localparam logic [31:0] MASK_B3      = 32'hff00_0000;
    localparam logic [31:0] NONE         = 32'h0000_0000;

    // One verdict as it travels on m_tuser and m_tdata.
    typedef struct packed {
        logic        accepted;
        fmt_t        fmt;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] stride;
        logic [31:0] bytes;
    } verdict_t;

    localparam verdict_t REJECTED = '0;

    // One row of the directed table. A patch overwrites one header word; noise
    // words without a start mark go first; a nonzero restart_at sends that many
    // words of the header and then starts it over.
    typedef struct packed {
        fmt_t        fmt;
        logic [31:0] width;
        logic [31:0] height;
        logic        pitch_en;
        logic [31:0] pitch;
        int          patch_at;
        logic [31:0] patch_val;
        int          noise_words;
        int          restart_at;
        logic        typed;
        verdict_t    want;
    } case_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [WORD_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata   = '0;   // [31:0] header_word
    logic                   s_tuser   = 1'b0; // [0] start_of_header
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [2:0] pixel_format, [34:3] image_width, [66:35] image_height,
    // [98:67] row_stride, [130:99] image_bytes
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;          // [0] accepted

    // Stimulus side state.
    logic [31:0] hdr_words [HDR_WORDS];
    logic [31:0] cur_magic   = MAGIC_RESET;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;
    int          quiet_cycles = 0;
    int          errors      = 0;
    case_row_t   rows [$];

    // Predictor state: its own copy of the magic register and header fields.
    verdict_t    pending_verdicts [$];
    verdict_t    last_verdict = '0;
    logic [31:0] pred_magic = MAGIC_RESET;
    logic [4:0]  word_pos   = '0;
    logic        hdr_open   = 1'b0;
    logic        hdr_bad    = 1'b0;
    logic [31:0] flags_w    = '0;
    logic [31:0] height_w   = '0;
    logic [31:0] width_w    = '0;
    logic [31:0] pitch_w    = '0;
    logic [31:0] pf_flags_w = '0;
    logic [31:0] bitcount_w = '0;
    logic [31:0] mask_r     = '0;
    logic [31:0] mask_g     = '0;
    logic [31:0] mask_b     = '0;
    logic [31:0] mask_a     = '0;

    dds_header_validator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Maps the pixel format words onto one of the six supported layouts.
    // Returns 0 when the combination is not supported.
    function automatic logic decode_layout(output fmt_t f);
        f = FMT_BGR24;
        case (pf_flags_w)
            PF_RGB: begin
                if (bitcount_w != 32'd24 || mask_g != MASK_B1 || mask_a != NONE) return 1'b0;
                if (mask_r == MASK_B2 && mask_b == MASK_B0) begin
                    f = FMT_BGR24;
                    return 1'b1;
                end
                if (mask_r == MASK_B0 && mask_b == MASK_B2) begin
                    f = FMT_RGB24;
                    return 1'b1;
                end
                return 1'b0;
            end
            PF_RGB | PF_ALPHA: begin
                if (bitcount_w != 32'd32 || mask_g != MASK_B1 || mask_a != MASK_B3) return 1'b0;
                if (mask_r == MASK_B2 && mask_b == MASK_B0) begin
                    f = FMT_BGRA32;
                    return 1'b1;
                end
                if (mask_r == MASK_B0 && mask_b == MASK_B2) begin
                    f = FMT_RGBA32;
                    return 1'b1;
                end
                return 1'b0;
            end
            PF_LUM: begin
                f = FMT_GRAY8;
                return bitcount_w == 32'd8 && mask_r == MASK_B0 && mask_g == NONE &&
                       mask_b == NONE && mask_a == NONE;
            end
            PF_LUM | PF_ALPHA: begin
                f = FMT_GRAYALPHA16;
                return bitcount_w == 32'd16 && mask_r == MASK_B0 && mask_g == NONE &&
                       mask_b == NONE && mask_a == MASK_B1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Works out the verdict once word 31 has been taken.
    function automatic verdict_t judge_header();
        verdict_t    v;
        fmt_t        f;
        logic [63:0] row_bytes;
        logic [63:0] total;
        logic [31:0] stride;
        logic [2:0]  px;
        v = REJECTED;
        if (hdr_bad || !decode_layout(f)) return v;
        if (width_w == 0 || height_w == 0) return v;
        case (f)
            FMT_BGR24, FMT_RGB24:   px = 3'd3;
            FMT_BGRA32, FMT_RGBA32: px = 3'd4;
            FMT_GRAYALPHA16:        px = 3'd2;
            default:                px = 3'd1;
        endcase
        row_bytes = 64'(width_w) * 64'(px);
        if (row_bytes > 64'hFFFF_FFFF) return v;
        stride = row_bytes[31:0];
        if ((flags_w & FL_PITCH) != 0) begin
            if (pitch_w < stride) return v;
            stride = pitch_w;
        end
        total = 64'(stride) * 64'(height_w);
        if (total > 64'hFFFF_FFFF) return v;
        v.accepted = 1'b1;
        v.fmt      = f;
        v.width    = width_w;
        v.height   = height_w;
        v.stride   = stride;
        v.bytes    = total[31:0];
        return v;
    endfunction

    // Advances the predictor by one accepted header word.
    task automatic predict_word(input logic [31:0] w, input logic st);
        logic bad;
        bad = 1'b0;
        if (st) begin
            hdr_open = 1'b1;
            hdr_bad  = 1'b0;
            word_pos = '0;
        end else if (!hdr_open) begin
            // A stray word outside a header is dropped.
            return;
        end
        case (word_pos)
            W_MAGIC:    bad = (w != pred_magic);
            W_SIZE:     bad = (w != HDR_SIZE);
            W_FLAGS: begin
                flags_w = w;
                bad = ((w & (FL_HEIGHT | FL_WIDTH)) != (FL_HEIGHT | FL_WIDTH)) ||
                      ((w & ~FLAGS_ALLOWED) != 0);
            end
            W_HEIGHT: begin
                height_w = w;
                bad = (w == 0);
            end
            W_WIDTH: begin
                width_w = w;
                bad = (w == 0);
            end
            W_PITCH:    pitch_w = w;
            W_PF_SIZE:  bad = (w != PF_SIZE);
            W_PF_FLAGS: pf_flags_w = w;
            W_BITCOUNT: bitcount_w = w;
            W_RMASK:    mask_r = w;
            W_GMASK:    mask_g = w;
            W_BMASK:    mask_b = w;
            W_AMASK:    mask_a = w;
            W_CAPS:     bad = ((w & ~CAPS_TEXTURE) != 0);
            // Depth, mipmaps, reserved words, fourcc and the later caps words.
            default:    bad = (w != 0);
        endcase
        if (bad) hdr_bad = 1'b1;
        if (word_pos == 5'(W_LAST)) begin
            hdr_open = 1'b0;
            word_pos = '0;
            pending_verdicts.push_back(judge_header());
        end else begin
            word_pos = word_pos + 5'd1;
        end
    endtask

    task automatic compare_verdict(input verdict_t want, input verdict_t got);
        if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0h, got %0h", want.accepted, got.accepted);
            errors++;
        end
        if (got.fmt !== want.fmt) begin
            $error("pixel_format: expected %0d, got %0d", want.fmt, got.fmt);
            errors++;
        end
        if (got.width !== want.width) begin
            $error("image_width: expected %0h, got %0h", want.width, got.width);
            errors++;
        end
        if (got.height !== want.height) begin
            $error("image_height: expected %0h, got %0h", want.height, got.height);
            errors++;
        end
        if (got.stride !== want.stride) begin
            $error("row_stride: expected %0h, got %0h", want.stride, got.stride);
            errors++;
        end
        if (got.bytes !== want.bytes) begin
            $error("image_bytes: expected %0h, got %0h", want.bytes, got.bytes);
            errors++;
        end
    endtask

    // All beats are sampled here at the clock edge. The output is checked
    // before the predictor takes an input beat; a verdict can never belong
    // to a word accepted at the same edge, so the order is safe.
    always @(posedge aclk) begin : monitor
        verdict_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.accepted = m_tuser;
                got.fmt      = fmt_t'(m_tdata[2:0]);
                got.width    = m_tdata[34:3];
                got.height   = m_tdata[66:35];
                got.stride   = m_tdata[98:67];
                got.bytes    = m_tdata[130:99];
                last_verdict = got;
                if (pending_verdicts.size() == 0) begin
                    $error("verdict beat arrived with no verdict pending");
                    errors++;
                end else begin
                    compare_verdict(pending_verdicts.pop_front(), got);
                end
            end
            if (cfg_valid && cfg_ready) pred_magic = cfg_data;
            if (s_tvalid && s_tready) predict_word(s_tdata, s_tuser);
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off when the
    // main thread flips hold_toggle. The hold is counted here, in cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a long run of cycles with no beat on any channel means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one word and returns at the edge where it is taken. Every call
    // starts right after a rising edge, so each step drives s_tvalid once.
    task automatic send_word(input logic [31:0] w, input logic st);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends the first n words of hdr_words, with the start mark on word zero.
    task automatic send_header(input int n);
        for (int i = 0; i < n; i++) send_word(hdr_words[i], i == W_MAGIC);
    endtask

    // Lets every queued verdict arrive, then gives the block time to settle.
    // The first edge lets the predictor take the last word before the check.
    task automatic wait_all_verdicts();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_magic(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_magic = v;
    endtask

    // Fills hdr_words with a well-formed header for the given layout and size.
    task automatic build_header(input fmt_t f, input logic [31:0] wd, input logic [31:0] ht,
                                input logic pen, input logic [31:0] pt);
        logic [31:0] fl, nb, r, g, b, a;
        case (f)
            FMT_BGR24:  {fl, nb, r, g, b, a} = {PF_RGB, 32'd24, MASK_B2, MASK_B1, MASK_B0, NONE};
            FMT_RGB24:  {fl, nb, r, g, b, a} = {PF_RGB, 32'd24, MASK_B0, MASK_B1, MASK_B2, NONE};
            FMT_BGRA32: {fl, nb, r, g, b, a} =
                            {PF_RGB | PF_ALPHA, 32'd32, MASK_B2, MASK_B1, MASK_B0, MASK_B3};
            FMT_RGBA32: {fl, nb, r, g, b, a} =
                            {PF_RGB | PF_ALPHA, 32'd32, MASK_B0, MASK_B1, MASK_B2, MASK_B3};
            FMT_GRAY8:  {fl, nb, r, g, b, a} = {PF_LUM, 32'd8, MASK_B0, NONE, NONE, NONE};
            default:    {fl, nb, r, g, b, a} =
                            {PF_LUM | PF_ALPHA, 32'd16, MASK_B0, NONE, NONE, MASK_B1};
        endcase
        foreach (hdr_words[i]) hdr_words[i] = '0;
        hdr_words[W_MAGIC]    = cur_magic;
        hdr_words[W_SIZE]     = HDR_SIZE;
        hdr_words[W_FLAGS]    = pen ? FLAGS_ALLOWED : FLAGS_BASE;
        hdr_words[W_HEIGHT]   = ht;
        hdr_words[W_WIDTH]    = wd;
        hdr_words[W_PITCH]    = pt;
        hdr_words[W_PF_SIZE]  = PF_SIZE;
        hdr_words[W_PF_FLAGS] = fl;
        hdr_words[W_BITCOUNT] = nb;
        hdr_words[W_RMASK]    = r;
        hdr_words[W_GMASK]    = g;
        hdr_words[W_BMASK]    = b;
        hdr_words[W_AMASK]    = a;
        hdr_words[W_CAPS]     = CAPS_TEXTURE;
    endtask

    // Mostly well-formed headers with random content; the rest carry a flipped
    // bit, a random word, are broken off early, or follow a burst of noise.
    task automatic send_random_header();
        logic [31:0] wd, ht, pt;
        int          mode;
        int          n;
        wd = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(1, 48));
        ht = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(1, 48));
        pt = ($urandom_range(3) == 0) ? 32'($urandom)
                                      : wd * $urandom_range(1, 4) + $urandom_range(0, 3);
        build_header(fmt_t'($urandom_range(5)), wd, ht, 1'($urandom_range(1)), pt);
        // The caps and pixel format flags are optional.
        if ($urandom_range(3) == 0) hdr_words[W_FLAGS] &= ~(FL_CAPS | FL_PIXFMT);
        if ($urandom_range(3) == 0) hdr_words[W_CAPS] = NONE;
        n    = HDR_WORDS;
        mode = $urandom_range(99);
        if (mode >= 60 && mode < 75) begin
            hdr_words[$urandom_range(W_LAST)] ^= 32'h1 << $urandom_range(31);
        end else if (mode >= 75 && mode < 85) begin
            hdr_words[$urandom_range(W_LAST)] = $urandom;
        end else if (mode >= 85 && mode < 93) begin
            // Broken off: the next start mark reopens the header.
            n = $urandom_range(1, W_LAST);
        end else if (mode >= 93) begin
            repeat ($urandom_range(1, 8)) send_word($urandom, $urandom_range(3) == 0);
        end
        send_header(n);
    endtask

    // One idling setting and one magic value, then a batch of random headers.
    // A clean header at the end closes any header left open, so the next
    // register write finds the block idle.
    task automatic run_phase(input int send_idle, input int recv_stall,
                             input logic [31:0] magic, input logic squeeze);
        wait_all_verdicts();
        write_magic(magic);
        idle_pct = send_idle;
        stall_pct <= recv_stall;
        if (squeeze) begin
            // Receiver holds off while well-formed headers keep coming, so the
            // job queue fills and s_tready has to drop.
            hold_toggle <= ~hold_toggle;
            repeat (PRESSURE_HEADERS) begin
                build_header(fmt_t'($urandom_range(5)), $urandom_range(1, 16),
                             $urandom_range(1, 16), 1'b0, NONE);
                send_header(HDR_WORDS);
            end
        end
        repeat (PHASE_HEADERS) send_random_header();
        build_header(FMT_GRAY8, 32'd8, 32'd2, 1'b0, NONE);
        send_header(HDR_WORDS);
        wait_all_verdicts();
    endtask

    initial begin : main
        case_row_t row;

        // Directed table: fmt, width, height, pitch_en, pitch, patch_at, patch_val,
        // noise_words, restart_at, typed, expected verdict.
        // Smallest image, typed verdict.
        rows.push_back('{FMT_BGR24, 32'd1, 32'd1, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_BGR24, 32'd1, 32'd1, 32'd3, 32'd3}});
        rows.push_back('{FMT_RGB24, 32'd2, 32'd3, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b0,
                         REJECTED});
        rows.push_back('{FMT_BGRA32, 32'd4, 32'd4, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_BGRA32, 32'd4, 32'd4, 32'd16, 32'd64}});
        rows.push_back('{FMT_RGBA32, 32'd5, 32'd2, 1'b1, 32'd24, NO_PATCH, NONE, 0, 0, 1'b0,
                         REJECTED});
        rows.push_back('{FMT_GRAY8, 32'd7, 32'd3, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b0,
                         REJECTED});
        rows.push_back('{FMT_GRAYALPHA16, 32'd3, 32'd3, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b0,
                         REJECTED});
        // Wrong magic, wrong header size.
        rows.push_back('{FMT_BGR24, 32'd2, 32'd2, 1'b0, NONE, W_MAGIC, NONE, 0, 0, 1'b1,
                         REJECTED});
        rows.push_back('{FMT_BGR24, 32'd2, 32'd2, 1'b0, NONE, W_SIZE, NONE, 0, 0, 1'b1,
                         REJECTED});
        // Zero width, zero height.
        rows.push_back('{FMT_GRAY8, NONE, 32'd2, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         REJECTED});
        rows.push_back('{FMT_GRAY8, 32'd2, NONE, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         REJECTED});
        // Pitch one byte short of the packed row, then exactly equal to it.
        rows.push_back('{FMT_RGBA32, 32'd4, 32'd2, 1'b1, 32'd15, NO_PATCH, NONE, 0, 0, 1'b1,
                         REJECTED});
        rows.push_back('{FMT_RGBA32, 32'd4, 32'd2, 1'b1, 32'd16, NO_PATCH, NONE, 0, 0, 1'b0,
                         REJECTED});
        // Widest gray image fits exactly.
        rows.push_back('{FMT_GRAY8, 32'hFFFF_FFFF, 32'd1, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_GRAY8, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}});
        // Stride one pixel past 32 bits, then exactly at the limit.
        rows.push_back('{FMT_BGR24, 32'h5555_5556, 32'd1, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         REJECTED});
        rows.push_back('{FMT_BGR24, 32'h5555_5555, 32'd1, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_BGR24, 32'h5555_5555, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}});
        // Byte count of exactly 2^32.
        rows.push_back('{FMT_GRAY8, 32'h1_0000, 32'h1_0000, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         REJECTED});
        // Tallest image, then the largest pitch.
        rows.push_back('{FMT_GRAY8, 32'd1, 32'hFFFF_FFFF, 1'b0, NONE, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_GRAY8, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}});
        rows.push_back('{FMT_GRAY8, 32'd1, 32'd1, 1'b1, 32'hFFFF_FFFF, NO_PATCH, NONE, 0, 0, 1'b1,
                         '{1'b1, FMT_GRAY8, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}});
        // Unknown flag bit, missing width flag.
        rows.push_back('{FMT_BGR24, 32'd3, 32'd3, 1'b0, NONE, W_FLAGS, FLAGS_BASE | 32'h10,
                         0, 0, 1'b1, REJECTED});
        rows.push_back('{FMT_BGR24, 32'd3, 32'd3, 1'b0, NONE, W_FLAGS, FLAGS_BASE & ~FL_WIDTH,
                         0, 0, 1'b1, REJECTED});
        // Nonzero depth, nonzero fourcc, extra caps bit, unsupported bit count.
        rows.push_back('{FMT_BGR24, 32'd3, 32'd3, 1'b0, NONE, W_DEPTH, 32'd1, 0, 0, 1'b1,
                         REJECTED});
        rows.push_back('{FMT_BGR24, 32'd3, 32'd3, 1'b0, NONE, W_FOURCC, 32'h3154_5844, 0, 0,
                         1'b1, REJECTED});
        rows.push_back('{FMT_BGR24, 32'd3, 32'd3, 1'b0, NONE, W_CAPS, CAPS_TEXTURE | FL_PITCH,
                         0, 0, 1'b1, REJECTED});
        rows.push_back('{FMT_RGB24, 32'd3, 32'd3, 1'b0, NONE, W_BITCOUNT, 32'd32, 0, 0, 1'b1,
                         REJECTED});
        // Stray words while idle are dropped; a start mark mid-header restarts.
        rows.push_back('{FMT_BGRA32, 32'd6, 32'd5, 1'b0, NONE, NO_PATCH, NONE, 3, 0, 1'b0,
                         REJECTED});
        rows.push_back('{FMT_RGB24, 32'd9, 32'd4, 1'b1, 32'd40, NO_PATCH, NONE, 0, 10, 1'b0,
                         REJECTED});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset magic, one header at a time. Rows with
        // a typed verdict are also held against the beat that actually came.
        foreach (rows[i]) begin
            row = rows[i];
            build_header(row.fmt, row.width, row.height, row.pitch_en, row.pitch);
            if (row.patch_at != NO_PATCH) hdr_words[row.patch_at] = row.patch_val;
            repeat (row.noise_words) send_word($urandom, 1'b0);
            if (row.restart_at != 0) send_header(row.restart_at);
            send_header(HDR_WORDS);
            wait_all_verdicts();
            if (row.typed) compare_verdict(row.want, last_verdict);
        end

        // Random phases: no idling with the long receiver hold, sender idle,
        // receiver stalling, then both. The magic sweeps its extremes, a
        // random value, and back to the reset value.
        run_phase(0, 0, 32'hFFFF_FFFF, 1'b1);
        run_phase(59, 0, 32'h0000_0000, 1'b0);
        run_phase(0, 59, $urandom, 1'b0);
        run_phase(25, 25, MAGIC_RESET, 1'b0);

        wait_all_verdicts();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
